### rtl/ordered_list_delete_by_value_macros.svh
// Assertion macros used by the checker file of the ordered list block.
`ifndef ORDERED_LIST_DELETE_BY_VALUE_MACROS_SVH
`define ORDERED_LIST_DELETE_BY_VALUE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define OLIST_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define OLIST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/olist_pkg.sv
// Shared constants and codes for the ordered list block.
package olist_pkg;

    // Store size and capacity floor
    localparam int MAX_ENTRIES  = 32;
    localparam int MIN_CAPACITY = 2;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] FLOOR_CAP =
        (MIN_CAPACITY < MAX_ENTRIES) ? CNT_W'(MIN_CAPACITY) : CNT_W'(MAX_ENTRIES);

    // Field widths
    localparam int REQ_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int CAP_W    = 7;
    localparam int RESIZE_W = 2;

    localparam int OUT_FIELDS_W = STATUS_W + DATA_W + COUNT_W + CAP_W + RESIZE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // Bit positions of the result fields in m_tdata
    localparam int STATUS_LSB = 0;
    localparam int COUNT_LSB  = STATUS_W + DATA_W;
    localparam int CAP_LSB    = COUNT_LSB + COUNT_W;
    localparam int RESIZE_LSB = CAP_LSB + CAP_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_PRINT  = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_SIZE   = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [RESIZE_W-1:0] {
        RSZ_NONE   = 2'd0,
        RSZ_DOUBLE = 2'd1,
        RSZ_HALVE  = 2'd2
    } resize_t;

endpackage

### rtl/ordered_list_delete_by_value.sv
// Top level of the ordered list: request sequencer, entry store and result register.
//
//  channel | beat fields                                   | handshake
//  --------+-----------------------------------------------+---------------------
//  s_      | tuser: req_type; tdata: value                 | s_tvalid / s_tready
//  m_      | tdata: status,data,entry_count,capacity,resize| m_tvalid / m_tready
//          | tlast: last                                   |
//
//  From the accepted beat to the result: size and empty print go straight to the
//  response, add passes through S_ADD, print reads each entry in turn, and delete
//  scans for the value, shifts later entries down and finishes, all through the single RAM read port.
//  s_tready is high only while the sequencer is idle.
//  Reset (aresetn low, synchronous) empties the list and sets capacity to the floor.
//  A stalled m_ beat holds; the sequencer waits on the result register.
module ordered_list_delete_by_value (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [olist_pkg::VALUE_W-1:0]       s_tdata,   // [31:0] value
    input  logic [olist_pkg::REQ_W-1:0]         s_tuser,   // [1:0] req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [33:2] data, [40:34] entry_count, [47:41] capacity,
    // [49:48] resize, rest zero
    output logic [olist_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                m_tlast
);
    import olist_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_PRN_RD,
        S_PRN_OUT,
        S_DEL_RD,
        S_DEL_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DEL_FIN,
        S_RESP
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       cap_reg, cap_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [VALUE_W-1:0]     val_reg, val_next;
    status_t                res_status_reg, res_status_next;
    resize_t                res_resize_reg, res_resize_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   m_tlast_reg, m_tlast_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                   ram_we, ram_re;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    logic [VALUE_W-1:0]     ram_wdata, ram_rdata;

    logic                   out_free;
    logic [CNT_W-1:0]       idx_inc;
    logic [CNT_W:0]         cap_dbl;
    logic [CNT_W-1:0]       cap_grow, cap_half, cap_shrink, cap_eff;
    logic                   grow;

    olist_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Shared index incrementer and capacity arithmetic
    always_comb begin
        idx_inc    = idx_reg + CNT_W'(1);
        cap_dbl    = {cap_reg, 1'b0};
        cap_grow   = (cap_dbl > (CNT_W + 1)'(MAX_ENTRIES)) ? MAX_CNT : cap_dbl[CNT_W-1:0];
        grow       = (count_reg >= cap_reg) && (cap_reg < MAX_CNT);
        cap_eff    = grow ? cap_grow : cap_reg;
        cap_half   = cap_reg >> 1;
        cap_shrink = (cap_half < FLOOR_CAP) ? FLOOR_CAP : cap_half;
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        cap_next        = cap_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_resize_next = res_resize_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tlast_next    = m_tlast_reg;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = idx_reg[IDX_W-1:0];
        ram_raddr       = idx_reg[IDX_W-1:0];
        ram_wdata       = ram_rdata;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    val_next        = s_tdata;
                    idx_next        = '0;
                    res_status_next = ST_OK;
                    res_resize_next = RSZ_NONE;
                    case (req_t'(s_tuser))
                        REQ_ADD:    state_next = S_ADD;
                        REQ_PRINT: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_RESP;
                            end else begin
                                state_next = S_PRN_RD;
                            end
                        end
                        REQ_DELETE: state_next = S_DEL_RD;
                        default:    state_next = S_RESP;
                    endcase
                end
            end

            // Grow if at capacity, then append when there is room
            S_ADD: begin
                cap_next = cap_eff;
                if (grow) begin
                    res_resize_next = RSZ_DOUBLE;
                end
                if ((count_reg < cap_eff) && (count_reg < MAX_CNT)) begin
                    ram_we     = 1'b1;
                    ram_waddr  = count_reg[IDX_W-1:0];
                    ram_wdata  = val_reg;
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    res_status_next = ST_FULL;
                end
                state_next = S_RESP;
            end

            S_PRN_RD: begin
                ram_re     = 1'b1;
                state_next = S_PRN_OUT;
            end

            // One beat per entry, last on the final one
            S_PRN_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = (idx_inc == count_reg);
                    m_tdata_next  = {OUT_PAD_W'(0), RSZ_NONE, CAP_W'(cap_reg),
                                     COUNT_W'(count_reg), ram_rdata, ST_OK};
                    if (idx_inc == count_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = S_PRN_RD;
                    end
                end
            end

            // Scan for the first match
            S_DEL_RD: begin
                if (idx_reg >= count_reg) begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_DEL_FIN;
                end else begin
                    ram_re     = 1'b1;
                    state_next = S_DEL_CMP;
                end
            end

            S_DEL_CMP: begin
                if (ram_rdata == val_reg) begin
                    state_next = S_SH_RD;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_DEL_RD;
                end
            end

            // Close the gap: entry k takes entry k+1
            S_SH_RD: begin
                if (idx_inc < count_reg) begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_inc[IDX_W-1:0];
                    state_next = S_SH_WR;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DEL_FIN;
                end
            end

            S_SH_WR: begin
                ram_we     = 1'b1;
                idx_next   = idx_inc;
                state_next = S_SH_RD;
            end

            // Shrink check runs after every delete
            S_DEL_FIN: begin
                if ((count_reg <= cap_half) && (cap_shrink != cap_reg)) begin
                    cap_next        = cap_shrink;
                    res_resize_next = RSZ_HALVE;
                end
                state_next = S_RESP;
            end

            S_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    m_tdata_next  = {OUT_PAD_W'(0), res_resize_reg, CAP_W'(cap_reg),
                                     COUNT_W'(count_reg), DATA_W'(0), res_status_reg};
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cap_reg      <= FLOOR_CAP;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cap_reg      <= cap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        idx_reg        <= idx_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_resize_reg <= res_resize_next;
        m_tlast_reg    <= m_tlast_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/olist_ram.sv
// Generic single-write, single-read RAM with registered read data.
module olist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds when not enabled
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/olist_chk.sv
// Port-level checker for the ordered list block, bound to its top level.
`include "ordered_list_delete_by_value_macros.svh"

module olist_chk (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [olist_pkg::VALUE_W-1:0]       s_tdata,
    input logic [olist_pkg::REQ_W-1:0]         s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [olist_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                                m_tlast
);
    import olist_pkg::*;

    logic [STATUS_W-1:0] f_status;
    logic [COUNT_W-1:0]  f_count;
    logic [CAP_W-1:0]    f_cap;
    logic [RESIZE_W-1:0] f_resize;
    logic                in_beat;

    assign f_status = m_tdata[STATUS_LSB +: STATUS_W];
    assign f_count  = m_tdata[COUNT_LSB +: COUNT_W];
    assign f_cap    = m_tdata[CAP_LSB +: CAP_W];
    assign f_resize = m_tdata[RESIZE_LSB +: RESIZE_W];
    assign in_beat  = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser);

    // A stalled result beat holds
    `OLIST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result beat changed")

    // One request at a time: input closes right after a beat
    `OLIST_ASSERT_NEXT(a_one_req, in_beat, !s_tready, "input open after an accepted beat")

    // Count never exceeds capacity, capacity stays within floor and store size
    `OLIST_ASSERT_IMPL(a_cap_range, m_tvalid,
        (f_count <= f_cap) && (f_cap >= COUNT_W'(FLOOR_CAP)) &&
        (f_cap <= COUNT_W'(MAX_ENTRIES)), "count or capacity out of range")

    // Empty print and every resized result is a single last beat
    `OLIST_ASSERT_IMPL(a_empty_last, m_tvalid && ((f_status == ST_EMPTY) ||
        (f_resize != RSZ_NONE)), m_tlast, "single-beat result without last")

endmodule

bind ordered_list_delete_by_value olist_chk u_olist_chk (.*);
